// ===== src/fdsr_pkg.sv =====
// Shared constants, register codes and types of the decrypt scale-and-round block.
package fdsr_pkg;

   // Fixed port widths
   localparam int COEFF_W   = 64;
   localparam int PLAIN_W   = 16;
   localparam int CSR_IDX_W = 3;

   // Default parameter values
   localparam int DEF_COEFF_BITS = 64;
   localparam int DEF_PLAIN_BITS = 16;

   // Register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CIPHER_MODULUS  = 3'd0,
      CSR_SCALE_DELTA     = 3'd1,
      CSR_HALF_DELTA      = 3'd2,
      CSR_UPPER_THRESHOLD = 3'd3,
      CSR_UPPER_INCREMENT = 3'd4
   } csr_index_type;

   // Reset values of the registers
   localparam logic [COEFF_W-1:0] RST_CIPHER_MODULUS  = 64'd2;
   localparam logic [COEFF_W-1:0] RST_SCALE_DELTA     = 64'd1;
   localparam logic [COEFF_W-1:0] RST_HALF_DELTA      = 64'd0;
   localparam logic [COEFF_W-1:0] RST_UPPER_THRESHOLD = 64'd1;
   localparam logic [COEFF_W-1:0] RST_UPPER_INCREMENT = 64'd0;

   // Register file contents; half_delta is held zero-extended
   typedef struct packed {
      logic [COEFF_W-1:0] cipher_modulus;
      logic [COEFF_W-1:0] scale_delta;
      logic [COEFF_W-1:0] half_delta;
      logic [COEFF_W-1:0] upper_threshold;
      logic [COEFF_W-1:0] upper_increment;
   } cfg_type;

endpackage

// ===== src/fdsr_req_if.sv =====
// Input channel: one ciphertext coefficient per transaction.
interface fdsr_req_if import fdsr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COEFF_W-1:0] combined_coeff;

   modport source (output valid, output combined_coeff, input ready);
   modport sink   (input valid, input combined_coeff, output ready);
endinterface

// ===== src/fdsr_rsp_if.sv =====
// Result channel: one plaintext coefficient and range flag per transaction.
interface fdsr_rsp_if import fdsr_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [PLAIN_W-1:0] plain_coeff;
   logic               input_out_of_range;

   modport source (output valid, output plain_coeff, output input_out_of_range, input ready);
   modport sink   (input valid, input plain_coeff, input input_out_of_range, output ready);
endinterface

// ===== src/fdsr_front.sv =====
// Front stages: rounding offset add, modular reduction and upper-half correction.
module fdsr_front import fdsr_pkg::*; #(
   parameter int COEFF_BITS = DEF_COEFF_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [COEFF_BITS-1:0] in_coeff,
   input  cfg_type               cfg,
   output logic                  out_valid,
   output logic                  out_flag,
   output logic [COEFF_BITS-1:0] out_value
);

   logic [COEFF_BITS-1:0] q_mod;
   logic [COEFF_BITS-1:0] h_off;
   logic [COEFF_BITS-1:0] thr;
   logic [COEFF_BITS-1:0] inc;

   logic                  s1_valid_ff, s1_valid_in;
   logic                  s1_flag_ff,  s1_flag_in;
   logic [COEFF_BITS:0]   s1_sum_ff,   s1_sum_in;
   logic                  s2_valid_ff, s2_valid_in;
   logic                  s2_flag_ff,  s2_flag_in;
   logic [COEFF_BITS-1:0] s2_val_ff,   s2_val_in;
   logic                  s3_valid_ff, s3_valid_in;
   logic                  s3_flag_ff,  s3_flag_in;
   logic [COEFF_BITS-1:0] s3_val_ff,   s3_val_in;

   // Reduce the registers to the working width
   assign q_mod = cfg.cipher_modulus[COEFF_BITS-1:0];
   assign h_off = cfg.half_delta[COEFF_BITS-1:0];
   assign thr   = cfg.upper_threshold[COEFF_BITS-1:0];
   assign inc   = cfg.upper_increment[COEFF_BITS-1:0];

   // Stage 1: flag out-of-range input, add the rounding offset with carry
   always_comb begin
      s1_valid_in = in_valid;
      s1_flag_in  = (in_coeff >= q_mod);
      s1_sum_in   = {1'b0, in_coeff} + {1'b0, h_off};
   end

   // Stage 2: subtract q on carry or when the sum reaches q
   always_comb begin
      s2_valid_in = s1_valid_ff;
      s2_flag_in  = s1_flag_ff;
      if (s1_sum_ff[COEFF_BITS] || (s1_sum_ff[COEFF_BITS-1:0] >= q_mod)) begin
         s2_val_in = s1_sum_ff[COEFF_BITS-1:0] - q_mod;
      end else begin
         s2_val_in = s1_sum_ff[COEFF_BITS-1:0];
      end
   end

   // Stage 3: pull values at or above the upper threshold down by the upper increment
   always_comb begin
      s3_valid_in = s2_valid_ff;
      s3_flag_in  = s2_flag_ff;
      if (s2_val_ff >= thr) begin
         s3_val_in = s2_val_ff - inc;
      end else begin
         s3_val_in = s2_val_ff;
      end
   end

   // Advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_flag_ff <= s1_flag_in;
         s1_sum_ff  <= s1_sum_in;
         s2_flag_ff <= s2_flag_in;
         s2_val_ff  <= s2_val_in;
         s3_flag_ff <= s3_flag_in;
         s3_val_ff  <= s3_val_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_flag  = s3_flag_ff;
   assign out_value = s3_val_ff;

endmodule

// ===== src/fdsr_div_step.sv =====
// One restoring division step: one quotient bit per pipeline stage.
module fdsr_div_step import fdsr_pkg::*; #(
   parameter int COEFF_BITS = DEF_COEFF_BITS,
   parameter int QUO_BITS   = DEF_PLAIN_BITS,
   parameter int BIT_POS    = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [COEFF_BITS-1:0] divisor,
   input  logic                  in_valid,
   input  logic                  in_flag,
   input  logic [COEFF_BITS-1:0] in_dividend,
   input  logic [COEFF_BITS-1:0] in_rem,
   input  logic [QUO_BITS-1:0]   in_quo,
   output logic                  out_valid,
   output logic                  out_flag,
   output logic [COEFF_BITS-1:0] out_dividend,
   output logic [COEFF_BITS-1:0] out_rem,
   output logic [QUO_BITS-1:0]   out_quo
);

   logic [COEFF_BITS:0]   partial;
   logic [COEFF_BITS:0]   diff;
   logic                  fits;
   logic [QUO_BITS:0]     quo_wide;

   logic                  valid_ff, valid_in;
   logic                  flag_ff;
   logic [COEFF_BITS-1:0] dividend_ff;
   logic [COEFF_BITS-1:0] rem_ff, rem_in;
   logic [QUO_BITS-1:0]   quo_ff, quo_in;

   // Bring down the next dividend bit, trial subtract the divisor
   always_comb begin
      partial  = {in_rem, in_dividend[BIT_POS]};
      diff     = partial - {1'b0, divisor};
      fits     = (partial >= {1'b0, divisor});
      rem_in   = fits ? diff[COEFF_BITS-1:0] : partial[COEFF_BITS-1:0];
      quo_wide = {in_quo, fits};
      quo_in   = quo_wide[QUO_BITS-1:0];
      valid_in = in_valid;
   end

   // Advance valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // Advance payload
   always_ff @(posedge clock) begin
      if (advance) begin
         flag_ff     <= in_flag;
         dividend_ff <= in_dividend;
         rem_ff      <= rem_in;
         quo_ff      <= quo_in;
      end
   end

   assign out_valid    = valid_ff;
   assign out_flag     = flag_ff;
   assign out_dividend = dividend_ff;
   assign out_rem      = rem_ff;
   assign out_quo      = quo_ff;

endmodule

// ===== src/fdsr_divider.sv =====
// Pipelined restoring divider: COEFF_BITS stages, low quotient bits kept.
module fdsr_divider import fdsr_pkg::*; #(
   parameter int COEFF_BITS = DEF_COEFF_BITS,
   parameter int QUO_BITS   = DEF_PLAIN_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [COEFF_BITS-1:0] divisor,
   input  logic                  in_valid,
   input  logic                  in_flag,
   input  logic [COEFF_BITS-1:0] in_dividend,
   output logic                  out_valid,
   output logic                  out_flag,
   output logic [QUO_BITS-1:0]   out_quo
);

   logic                  valid_w    [0:COEFF_BITS];
   logic                  flag_w     [0:COEFF_BITS];
   logic [COEFF_BITS-1:0] dividend_w [0:COEFF_BITS];
   logic [COEFF_BITS-1:0] rem_w      [0:COEFF_BITS];
   logic [QUO_BITS-1:0]   quo_w      [0:COEFF_BITS];

   // Start with an empty remainder and quotient
   assign valid_w[0]    = in_valid;
   assign flag_w[0]     = in_flag;
   assign dividend_w[0] = in_dividend;
   assign rem_w[0]      = '0;
   assign quo_w[0]      = '0;

   // Chain the steps, most significant dividend bit first
   for (genvar k = 0; k < COEFF_BITS; k++) begin : g_step
      fdsr_div_step #(
         .COEFF_BITS (COEFF_BITS),
         .QUO_BITS   (QUO_BITS),
         .BIT_POS    (COEFF_BITS - 1 - k)
      ) u_step (
         .clock        (clock),
         .reset        (reset),
         .advance      (advance),
         .divisor      (divisor),
         .in_valid     (valid_w[k]),
         .in_flag      (flag_w[k]),
         .in_dividend  (dividend_w[k]),
         .in_rem       (rem_w[k]),
         .in_quo       (quo_w[k]),
         .out_valid    (valid_w[k+1]),
         .out_flag     (flag_w[k+1]),
         .out_dividend (dividend_w[k+1]),
         .out_rem      (rem_w[k+1]),
         .out_quo      (quo_w[k+1])
      );
   end

   assign out_valid = valid_w[COEFF_BITS];
   assign out_flag  = flag_w[COEFF_BITS];
   assign out_quo   = quo_w[COEFF_BITS];

endmodule

// ===== src/fv_decrypt_scale_round_core.sv =====
// Top level of the decrypt scale-and-round block: registers, pipeline and output buffer.
// Path from transaction accept to result on rsp: front stages, divider stages, output register.
// Throughput: one transaction per cycle while the skid entry is empty; the divider retires one quotient bit per stage.
// A two-entry output buffer keeps req ready while one result waits on rsp.
// Reset (synchronous, active high) empties the pipeline and restores register defaults.
module fv_decrypt_scale_round_core import fdsr_pkg::*; #(
   parameter int COEFF_BITS = DEF_COEFF_BITS,
   parameter int PLAIN_BITS = DEF_PLAIN_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [COEFF_W-1:0]   csr_wdata,
   fdsr_req_if.sink             req,
   fdsr_rsp_if.source           rsp
);

   localparam int QUO_BITS = (PLAIN_BITS < PLAIN_W) ? PLAIN_BITS : PLAIN_W;

   cfg_type               cfg_ff, cfg_in;
   logic                  advance;
   logic                  front_valid;
   logic                  front_flag;
   logic [COEFF_BITS-1:0] front_value;
   logic                  div_valid;
   logic                  div_flag;
   logic [QUO_BITS-1:0]   div_quo;
   logic                  push;
   logic                  pop;

   logic                  out_valid_ff, out_valid_in;
   logic                  out_flag_ff,  out_flag_in;
   logic [QUO_BITS-1:0]   out_quo_ff,   out_quo_in;
   logic                  skid_valid_ff, skid_valid_in;
   logic                  skid_flag_ff,  skid_flag_in;
   logic [QUO_BITS-1:0]   skid_quo_ff,   skid_quo_in;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_CIPHER_MODULUS:  cfg_in.cipher_modulus  = csr_wdata;
            CSR_SCALE_DELTA:     cfg_in.scale_delta     = csr_wdata;
            CSR_HALF_DELTA:      cfg_in.half_delta      = {1'b0, csr_wdata[COEFF_W-2:0]};
            CSR_UPPER_THRESHOLD: cfg_in.upper_threshold = csr_wdata;
            CSR_UPPER_INCREMENT: cfg_in.upper_increment = csr_wdata;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cipher_modulus  <= RST_CIPHER_MODULUS;
         cfg_ff.scale_delta     <= RST_SCALE_DELTA;
         cfg_ff.half_delta      <= RST_HALF_DELTA;
         cfg_ff.upper_threshold <= RST_UPPER_THRESHOLD;
         cfg_ff.upper_increment <= RST_UPPER_INCREMENT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Hold the whole pipeline while the skid entry is occupied
   assign advance   = !skid_valid_ff;
   assign req.ready = advance;

   fdsr_front #(
      .COEFF_BITS (COEFF_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req.valid),
      .in_coeff  (req.combined_coeff[COEFF_BITS-1:0]),
      .cfg       (cfg_ff),
      .out_valid (front_valid),
      .out_flag  (front_flag),
      .out_value (front_value)
   );

   fdsr_divider #(
      .COEFF_BITS (COEFF_BITS),
      .QUO_BITS   (QUO_BITS)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .divisor     (cfg_ff.scale_delta[COEFF_BITS-1:0]),
      .in_valid    (front_valid),
      .in_flag     (front_flag),
      .in_dividend (front_value),
      .out_valid   (div_valid),
      .out_flag    (div_flag),
      .out_quo     (div_quo)
   );

   // Output register with skid entry
   assign push = div_valid && advance;
   assign pop  = out_valid_ff && rsp.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_flag_in   = out_flag_ff;
      out_quo_in    = out_quo_ff;
      skid_valid_in = skid_valid_ff;
      skid_flag_in  = skid_flag_ff;
      skid_quo_in   = skid_quo_ff;
      if (!out_valid_ff || pop) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_flag_in   = skid_flag_ff;
            out_quo_in    = skid_quo_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_flag_in  = div_flag;
            out_quo_in   = div_quo;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_flag_in  = div_flag;
         skid_quo_in   = div_quo;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_flag_ff  <= out_flag_in;
      out_quo_ff   <= out_quo_in;
      skid_flag_ff <= skid_flag_in;
      skid_quo_ff  <= skid_quo_in;
   end

   assign rsp.valid              = out_valid_ff;
   assign rsp.plain_coeff        = PLAIN_W'(out_quo_ff);
   assign rsp.input_out_of_range = out_flag_ff;

endmodule
